/* rtl/core/mtf_zero_run_encoder_defines.svh */
// ----------------------------------------------------------------------------
// MTF zero-run encoder assertion macros
// Shared concurrent assertion forms for the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef MTF_ZERO_RUN_ENCODER_DEFINES_SVH
`define MTF_ZERO_RUN_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MTFZRE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define MTFZRE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mtfzre_pkg.sv */
// ----------------------------------------------------------------------------
// MTF zero-run encoder package
// Shared widths, codes and control structures of the encoder.
// ----------------------------------------------------------------------------
package mtfzre_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = 8;
    localparam int SYM_W       = 8;
    localparam int POS_W       = 15;
    localparam int RUN_W       = 16;

    localparam logic [RUN_W-1:0] RUN_CAP     = 16'd65534;
    localparam logic [SYM_W-1:0] ESC_CODE    = 8'd255;
    localparam logic [SYM_W-1:0] ESC_POS_MIN = 8'd254;

    typedef struct packed {
        logic init;
        logic shift;
    } tbl_ctrl_t;

    typedef struct packed {
        logic             front;
        logic [IDX_W-1:0] pos;
    } tbl_stat_t;

endpackage

/* rtl/core/mtfzre_cell.sv */
// ----------------------------------------------------------------------------
// MTF table cell
// Holds one table entry, loaded with its initial value on init, compares it
// with the incoming symbol and takes its left neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
module mtfzre_cell (
    input  logic                            clk,
    input  mtfzre_pkg::tbl_ctrl_t           ctrl,
    input  logic                            shift_en,
    input  logic [mtfzre_pkg::SYM_W-1:0]    init_value,
    input  logic [mtfzre_pkg::SYM_W-1:0]    left_entry,
    input  logic [mtfzre_pkg::SYM_W-1:0]    cmp_sym,
    output logic [mtfzre_pkg::SYM_W-1:0]    entry,
    output logic                            hit
);

    logic [mtfzre_pkg::SYM_W-1:0] entry_reg;
    logic                         hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            entry_reg <= init_value;
        end
        else if (shift_en)
        begin
            entry_reg <= left_entry;
        end
        hit_reg <= (entry_reg == cmp_sym);
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

/* rtl/core/mtfzre_table.sv */
// ----------------------------------------------------------------------------
// MTF table
// A row of 256 cells with a suffix-OR tree for the shift enables and an
// encoder that turns the match vector into a table position.
// ----------------------------------------------------------------------------
`include "mtf_zero_run_encoder_defines.svh"

module mtfzre_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mtfzre_pkg::tbl_ctrl_t           ctrl,
    input  logic [mtfzre_pkg::SYM_W-1:0]    cmp_sym,
    input  logic [mtfzre_pkg::SYM_W-1:0]    front_sym,
    output mtfzre_pkg::tbl_stat_t           stat
);

    localparam int DEPTH = mtfzre_pkg::TABLE_DEPTH;
    localparam int IW    = mtfzre_pkg::IDX_W;

    logic [mtfzre_pkg::SYM_W-1:0] entry_vec [DEPTH];
    logic [DEPTH-1:0]             hit_vec;
    logic [DEPTH-1:0]             shift_vec;
    logic [DEPTH-1:0]             sfx [IW+1];
    logic [DEPTH-1:0]             msk [IW];
    logic [IW-1:0]                pos;

    always_comb
    begin
        sfx[0] = hit_vec;
        for (int l = 0; l < IW; l++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i + (1 << l) < DEPTH)
                begin
                    sfx[l+1][i] = sfx[l][i] | sfx[l][i + (1 << l)];
                end
                else
                begin
                    sfx[l+1][i] = sfx[l][i];
                end
            end
        end
    end

    always_comb
    begin
        shift_vec[0] = ctrl.shift;
        for (int k = 1; k < DEPTH; k++)
        begin
            shift_vec[k] = ctrl.shift & sfx[IW][k];
        end
    end

    always_comb
    begin
        logic [IW-1:0] idx;
        for (int b = 0; b < IW; b++)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                idx       = IW'(k);
                msk[b][k] = hit_vec[k] & idx[b];
            end
            pos[b] = |msk[b];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [mtfzre_pkg::SYM_W-1:0] left;
            if (g == 0)
            begin : g_head
                assign left = front_sym;
            end
            else
            begin : g_body
                assign left = entry_vec[g-1];
            end
            mtfzre_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .shift_en   (shift_vec[g]),
                .init_value (mtfzre_pkg::SYM_W'(g)),
                .left_entry (left),
                .cmp_sym    (cmp_sym),
                .entry      (entry_vec[g]),
                .hit        (hit_vec[g])
            );
        end
    endgenerate

    assign stat.front = hit_vec[0];
    assign stat.pos   = pos;

    `MTFZRE_ASSERT_IMPLIES(a_hit_onehot, clk, rst_n, ctrl.shift, $onehot(hit_vec), "Symbol not found exactly once in the table.")

endmodule

/* rtl/core/mtf_zero_run_encoder.sv */
// ----------------------------------------------------------------------------
// MTF zero-run encoder
// Move-to-front coder with bijective base-2 zero-run coding and an
// end-of-block marker carrying the primary index position.
// ----------------------------------------------------------------------------
// The results of an accepted symbol are registered at the output from ST_FLUSH, ST_CODE or ST_POS after ST_MOVE.
// A new symbol is accepted only in ST_IDLE, once the previous one is fully coded; m_tready stalls output.
// After the final item of a block, ST_INIT reloads the 256-cell table.
// Each cell registers its compare; ST_MOVE shifts the cell row up to the hit.
// Reset: asynchronous, active low; the table is loaded in ST_INIT, the state entered on reset.
`include "mtf_zero_run_encoder_defines.svh"

module mtf_zero_run_encoder #(
    parameter int MAX_BLOCK = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [0:0]  s_tuser,   // [0] is_primary
    input  logic        s_tlast,   // last_symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [22:8] primary_position, [23] zero
    output logic        m_tlast    // last_out
);

    localparam int SW = mtfzre_pkg::SYM_W;
    localparam int PW = mtfzre_pkg::POS_W;
    localparam int RW = mtfzre_pkg::RUN_W;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOVE,
        ST_FLUSH,
        ST_CODE,
        ST_POS
    } state_t;

    state_t                      state_reg, state_next;
    logic [SW-1:0]               sym_reg, sym_next;
    logic                        last_reg, last_next;
    logic                        front_reg, front_next;
    logic [mtfzre_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [RW-1:0]               run_reg, run_next;
    logic [RW-1:0]               v_reg, v_next;
    logic [PW-1:0]               pc_reg, pc_next;
    logic [PW-1:0]               prim_reg, prim_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0]               out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic [PW-1:0]               out_prim_reg, out_prim_next;

    mtfzre_pkg::tbl_ctrl_t       tctrl;
    mtfzre_pkg::tbl_stat_t       tstat;

    logic                        out_free;
    logic                        emit_en;
    logic [SW-1:0]               emit_byte;
    logic                        emit_last;
    logic [RW-1:0]               run_f;
    logic                        do_flush;
    logic                        flush_done;
    logic [PW+1:0]               pc_inc;

    mtfzre_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tctrl),
        .cmp_sym   (s_tdata),
        .front_sym (sym_reg),
        .stat      (tstat)
    );

    assign out_free   = !m_tvalid_reg || m_tready;
    assign pc_inc     = {2'b00, pc_reg} + (PW+2)'(1);
    assign flush_done = (v_reg[RW-1:2] == '0);

    always_comb
    begin
        if (tstat.front && (run_reg < mtfzre_pkg::RUN_CAP))
        begin
            run_f = run_reg + RW'(1);
        end
        else
        begin
            run_f = run_reg;
        end
        do_flush = tstat.front ? last_reg : (run_reg != '0);
    end

    always_comb
    begin
        state_next    = state_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        front_next    = front_reg;
        pos_next      = pos_reg;
        run_next      = run_reg;
        v_next        = v_reg;
        pc_next       = pc_reg;
        prim_next     = prim_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_prim_next = out_prim_reg;
        tctrl         = '0;
        emit_en       = 1'b0;
        emit_byte     = '0;
        emit_last     = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                tctrl.init = 1'b1;
                run_next   = '0;
                pc_next    = '0;
                prim_next  = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sym_next  = s_tdata;
                    last_next = s_tlast;
                    if (s_tuser[0])
                    begin
                        prim_next = pc_reg;
                    end
                    if (pc_inc == (PW+2)'(MAX_BLOCK))
                    begin
                        pc_next = '0;
                    end
                    else
                    begin
                        pc_next = pc_inc[PW-1:0];
                    end
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                tctrl.shift = !tstat.front;
                front_next  = tstat.front;
                pos_next    = tstat.pos;
                v_next      = run_f + RW'(1);
                run_next    = do_flush ? '0 : run_f;
                if (do_flush)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!tstat.front)
                begin
                    state_next = ST_CODE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    emit_byte = {{(SW-1){1'b0}}, v_reg[0]};
                    emit_last = last_reg && front_reg && flush_done;
                    v_next    = v_reg >> 1;
                    if (flush_done)
                    begin
                        state_next = front_reg ? ST_INIT : ST_CODE;
                    end
                end
            end
            ST_CODE:
            begin
                if (out_free)
                begin
                    emit_en = 1'b1;
                    if (pos_reg >= mtfzre_pkg::ESC_POS_MIN)
                    begin
                        emit_byte  = mtfzre_pkg::ESC_CODE;
                        state_next = ST_POS;
                    end
                    else
                    begin
                        emit_byte  = pos_reg + SW'(1);
                        emit_last  = last_reg;
                        state_next = last_reg ? ST_INIT : ST_IDLE;
                    end
                end
            end
            ST_POS:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = pos_reg;
                    emit_last  = last_reg;
                    state_next = last_reg ? ST_INIT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        if (emit_en)
        begin
            m_tvalid_next = 1'b1;
            out_byte_next = emit_byte;
            out_last_next = emit_last;
            out_prim_next = emit_last ? prim_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            last_reg     <= 1'b0;
            front_reg    <= 1'b0;
            run_reg      <= '0;
            pc_reg       <= '0;
            prim_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            front_reg    <= front_next;
            run_reg      <= run_next;
            pc_reg       <= pc_next;
            prim_reg     <= prim_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        pos_reg      <= pos_next;
        v_reg        <= v_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_prim_reg <= out_prim_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_prim_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    `MTFZRE_ASSERT_ALWAYS(a_run_cap, clk, rst_n, run_reg <= mtfzre_pkg::RUN_CAP, "Zero run exceeds its cap.")
    `MTFZRE_ASSERT_IMPLIES(a_flush_digit, clk, rst_n, state_reg == ST_FLUSH, v_reg > RW'(1), "Run flush started without a digit to send.")
    `MTFZRE_ASSERT_IMPLIES(a_prim_zero, clk, rst_n, m_tvalid && !m_tlast, m_tdata[22:8] == '0, "Primary position set on a non-final transaction.")
    `MTFZRE_ASSERT_IMPLIES(a_accept_move, clk, rst_n, s_tvalid && s_tready, ##1 (state_reg == ST_MOVE), "Accepted transaction did not reach the table update.")

endmodule
